// ----- hw/rtl/twmm_pkg.sv -----
// ----------------------------------------------------------------------------
// twmm_pkg
// shared widths, types and helpers of the three-axis window statistics block
// ----------------------------------------------------------------------------
package twmm_pkg;

    localparam int MAX_WINDOW     = 8;
    localparam int DEFAULT_WINDOW = 6;
    localparam int NUM_AXES       = 3;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 4;
    localparam int INDEX_W        = 3;
    localparam int POS_W          = $clog2(MAX_WINDOW);
    localparam int CNT_W          = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W          = SAMPLE_W + POS_W;
    localparam int AXIS_W         = $clog2(NUM_AXES);
    localparam int DIV_STEPS      = SAMPLE_W / 2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [CFG_W-1:0]    t_cfg;
    typedef logic [INDEX_W-1:0]  t_index;

    typedef t_sample [NUM_AXES-1:0] t_sample_vec;

    typedef struct packed {
        t_sample lowest;
        t_sample highest;
        t_sum    total;
    } t_axis_stats;

    typedef t_axis_stats [NUM_AXES-1:0] t_stats_vec;

    typedef struct packed {
        t_pos   pos;
        t_count count;
        logic   done;
    } t_window_pos;

    // zero acts as one, large values clamp to the window depth
    function automatic t_count eff_len(input t_cfg wl);
        t_count len;
        if (wl == '0) begin
            len = t_count'(1);
        end else if (32'(wl) > MAX_WINDOW) begin
            len = t_count'(MAX_WINDOW);
        end else begin
            len = t_count'(wl);
        end
        return len;
    endfunction

endpackage

// ----- hw/rtl/twmm_ifs.sv -----
// ----------------------------------------------------------------------------
// twmm channel interfaces
// sample input, statistics output and window length write channels
// ----------------------------------------------------------------------------
interface twmm_in_if;
    import twmm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample x_sample;
    t_sample y_sample;
    t_sample z_sample;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    output ready);
endinterface

interface twmm_out_if;
    import twmm_pkg::*;

    logic    valid;
    logic    ready;
    t_index  sample_index;
    logic    window_done;
    t_sample x_mean;
    t_sample x_lowest;
    t_sample x_highest;
    t_sample y_mean;
    t_sample y_lowest;
    t_sample y_highest;
    t_sample z_mean;
    t_sample z_lowest;
    t_sample z_highest;

    modport source (output valid, output sample_index, output window_done,
                    output x_mean, output x_lowest, output x_highest,
                    output y_mean, output y_lowest, output y_highest,
                    output z_mean, output z_lowest, output z_highest,
                    input ready);
    modport sink   (input valid, input sample_index, input window_done,
                    input x_mean, input x_lowest, input x_highest,
                    input y_mean, input y_lowest, input y_highest,
                    input z_mean, input z_lowest, input z_highest,
                    output ready);
endinterface

interface twmm_cfg_if;
    import twmm_pkg::*;

    logic valid;
    logic ready;
    t_cfg window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// ----- hw/rtl/triaxis_window_min_max_mean_unit.sv -----
// ----------------------------------------------------------------------------
// triaxis_window_min_max_mean_unit
// three-axis block window minimum, maximum and mean tracker
//
// i_in takes one x/y/z sample word. for every word one result word leaves on
// o_out: position in the window, window-done flag and, per axis, the minimum,
// maximum and truncated mean of the window so far. i_cfg writes the window
// length (zero acts as one, values above 8 clamp to 8); it is always ready.
// a sample word goes from accept to result in order: the extremes and sums
// update at the accept edge, then the shared divider takes each axis in turn
// (one load, 8 radix-4 steps over the 16 quotient bits and one to take the
// quotient), then the output register loads. i_in is ready again once the
// result is loaded; it takes no new word while one is in work. the next
// word may be taken while a result waits in the output register; a stalled
// receiver blocks the block only when a new result is ready to load. reset
// clears the window position, sums and extremes, sets the window length to 6
// and drops o_out valid.
// ----------------------------------------------------------------------------
module triaxis_window_min_max_mean_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    twmm_in_if.sink    i_in,
    twmm_out_if.source o_out,
    twmm_cfg_if.sink   i_cfg
);
    import twmm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [AXIS_W-1:0] r_axis;
    t_cfg              r_window_len;
    t_pos              r_pos;
    logic              r_done;
    t_count            r_count;
    t_sample_vec       r_mean;

    logic              r_out_valid;
    t_index            r_out_index;
    logic              r_out_done;
    t_sample_vec       r_out_mean;
    t_stats_vec        r_out_stats;

    logic              accept;
    logic              push;
    t_sample_vec       samples;
    t_stats_vec        stats;
    t_window_pos       pos;
    logic              div_done;
    t_sample           quotient;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign push        = (r_state == S_PUSH) && (!r_out_valid || o_out.ready);

    assign samples[0] = i_in.x_sample;
    assign samples[1] = i_in.y_sample;
    assign samples[2] = i_in.z_sample;

    twmm_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_samples (samples),
        .i_win_len (eff_len(r_window_len)),
        .o_stats   (stats),
        .o_pos     (pos)
    );

    twmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (stats[r_axis].total),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_state = (r_axis == LAST_AXIS) ? S_PUSH : S_START;
                end
            end
            S_PUSH: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_axis       <= '0;
            r_window_len <= t_cfg'(DEFAULT_WINDOW);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window_len <= i_cfg.window_length;
            end
            if (accept) begin
                r_axis <= '0;
            end else if (r_state == S_WAIT && div_done && r_axis != LAST_AXIS) begin
                r_axis <= r_axis + AXIS_W'(1);
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos   <= pos.pos;
            r_done  <= pos.done;
            r_count <= pos.count;
        end
        if (r_state == S_WAIT && div_done) begin
            r_mean[r_axis] <= quotient;
        end
        if (push) begin
            r_out_index <= t_index'(r_pos);
            r_out_done  <= r_done;
            r_out_mean  <= r_mean;
            r_out_stats <= stats;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_index = r_out_index;
    assign o_out.window_done  = r_out_done;
    assign o_out.x_mean       = r_out_mean[0];
    assign o_out.x_lowest     = r_out_stats[0].lowest;
    assign o_out.x_highest    = r_out_stats[0].highest;
    assign o_out.y_mean       = r_out_mean[1];
    assign o_out.y_lowest     = r_out_stats[1].lowest;
    assign o_out.y_highest    = r_out_stats[1].highest;
    assign o_out.z_mean       = r_out_mean[2];
    assign o_out.z_lowest     = r_out_stats[2].lowest;
    assign o_out.z_highest    = r_out_stats[2].highest;

endmodule

// ----- hw/rtl/twmm_acc.sv -----
// ----------------------------------------------------------------------------
// twmm_acc
// per-axis running minimum, maximum and sum plus window position counter
// ----------------------------------------------------------------------------
module twmm_acc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  twmm_pkg::t_sample_vec i_samples,
    input  twmm_pkg::t_count      i_win_len,
    output twmm_pkg::t_stats_vec  o_stats,
    output twmm_pkg::t_window_pos o_pos
);
    import twmm_pkg::*;

    t_pos       r_seen;
    t_stats_vec r_stats;
    logic       first;

    assign first       = (r_seen == '0);
    assign o_pos.pos   = r_seen;
    assign o_pos.count = t_count'(r_seen) + t_count'(1);
    assign o_pos.done  = (o_pos.count >= i_win_len);
    assign o_stats     = r_stats;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_stats <= '0;
        end else if (i_load) begin
            r_seen <= o_pos.done ? '0 : t_pos'(o_pos.count);
            for (int a = 0; a < NUM_AXES; a++) begin
                if (first) begin
                    r_stats[a].lowest  <= i_samples[a];
                    r_stats[a].highest <= i_samples[a];
                    r_stats[a].total   <= t_sum'(i_samples[a]);
                end else begin
                    if (i_samples[a] < r_stats[a].lowest) begin
                        r_stats[a].lowest <= i_samples[a];
                    end
                    if (i_samples[a] > r_stats[a].highest) begin
                        r_stats[a].highest <= i_samples[a];
                    end
                    r_stats[a].total <= r_stats[a].total + t_sum'(i_samples[a]);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/twmm_div.sv -----
// ----------------------------------------------------------------------------
// twmm_div
// shared restoring divider, two quotient bits per cycle, sum by sample count
// ----------------------------------------------------------------------------
module twmm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  twmm_pkg::t_sum    i_dividend,
    input  twmm_pkg::t_count  i_divisor,
    output logic              o_done,
    output twmm_pkg::t_sample o_quotient
);
    import twmm_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    t_count             r_div;
    t_count             r_rem;
    t_sample            r_num;
    t_sample            r_quo;

    logic [CNT_W:0]     w1;
    logic [CNT_W:0]     w2;
    logic               q1;
    logic               q2;
    t_count             rm1;
    t_count             rm2;

    always_comb begin
        w1  = {r_rem, r_num[SAMPLE_W-1]};
        q1  = (w1 >= {1'b0, r_div});
        rm1 = q1 ? t_count'(w1 - {1'b0, r_div}) : w1[CNT_W-1:0];
        w2  = {rm1, r_num[SAMPLE_W-2]};
        q2  = (w2 >= {1'b0, r_div});
        rm2 = q2 ? t_count'(w2 - {1'b0, r_div}) : w2[CNT_W-1:0];
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient fits the sample width, so the top dividend bits start as remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= t_count'(i_dividend[SUM_W-1:SAMPLE_W]);
            r_num <= i_dividend[SAMPLE_W-1:0];
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= rm2;
            r_num <= {r_num[SAMPLE_W-3:0], 2'b00};
            r_quo <= {r_quo[SAMPLE_W-3:0], q1, q2};
        end
    end

endmodule

// ----- hw/rtl/twmm_checker.sv -----
// ----------------------------------------------------------------------------
// twmm_checker
// port-level checks of the window statistics block, bound to the top level
// ----------------------------------------------------------------------------
module twmm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input twmm_pkg::t_index  i_out_index,
    input twmm_pkg::t_sample i_out_x_mean
);
    import twmm_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a word in work blocks the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready right after accept");

    // a result never appears in the cycle after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result too soon after accept");

    // a result is loaded only while the input side is closed
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result loaded while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_index) && $stable(i_out_x_mean))
        else $error("stalled result changed");

endmodule

bind triaxis_window_min_max_mean_unit twmm_checker u_twmm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_index  (o_out.sample_index),
    .i_out_x_mean (o_out.x_mean)
);
